// ----- sv/icv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types, register map, status codes and the byte-wide CRC-32 update
// for the image CRC-32 verifier.
// ----------------------------------------------------------------------------
package icv_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [15:0] ALL16    = 16'hFFFF;

    localparam int unsigned ADDR_W = 5;

    // register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_EXPECTED_CRC  = 3'd0,
        REG_HEADER_UID    = 3'd1,
        REG_HEADER_LENGTH = 3'd2,
        REG_HEADER_ROM    = 3'd3,
        REG_HEADER_VER    = 3'd4,
        REG_PART_ID       = 3'd5,
        REG_STACK_ID      = 3'd6,
        REG_BACKUP_MODE   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_ABNORMAL = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_ERASED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] expected_crc;
        logic [31:0] header_uid;
        logic [15:0] header_length;
        logic [15:0] header_rom_version;
        logic [15:0] header_version;
        logic [31:0] part_identifier;
        logic [31:0] stack_identifier;
        logic        backup_mode;
    } cfg_t;

    // finished image word handed from the CRC stage to the result stage
    typedef struct packed {
        logic        valid;
        logic [31:0] crc;
    } crc_res_t;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/icv_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_cfg_regs
// APB register file holding expected CRC, header fields, IDs and mode.
// ----------------------------------------------------------------------------
module icv_cfg_regs
    import icv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_EXPECTED_CRC:  cfg_next.expected_crc       = pwdata;
                REG_HEADER_UID:    cfg_next.header_uid         = pwdata;
                REG_HEADER_LENGTH: cfg_next.header_length      = pwdata[15:0];
                REG_HEADER_ROM:    cfg_next.header_rom_version = pwdata[15:0];
                REG_HEADER_VER:    cfg_next.header_version     = pwdata[15:0];
                REG_PART_ID:       cfg_next.part_identifier    = pwdata;
                REG_STACK_ID:      cfg_next.stack_identifier   = pwdata;
                REG_BACKUP_MODE:   cfg_next.backup_mode        = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EXPECTED_CRC:  prdata = cfg_reg.expected_crc;
            REG_HEADER_UID:    prdata = cfg_reg.header_uid;
            REG_HEADER_LENGTH: prdata = {16'd0, cfg_reg.header_length};
            REG_HEADER_ROM:    prdata = {16'd0, cfg_reg.header_rom_version};
            REG_HEADER_VER:    prdata = {16'd0, cfg_reg.header_version};
            REG_PART_ID:       prdata = cfg_reg.part_identifier;
            REG_STACK_ID:      prdata = cfg_reg.stack_identifier;
            REG_BACKUP_MODE:   prdata = {31'd0, cfg_reg.backup_mode};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/icv_crc_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_crc_stage
// Input register and running CRC-32; hands the CRC on at the last byte.
// ----------------------------------------------------------------------------
module icv_crc_stage
    import icv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        res_full,
    output crc_res_t    res
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] crc_upd;
    logic        blocked;
    logic        advance;
    logic        accept;

    assign crc_upd = crc32_byte(running_crc_reg, s1_byte_reg);

    // a last byte waits while the result register is still held
    assign blocked  = s1_valid_reg && s1_last_reg && res_full;
    assign advance  = s1_valid_reg && !blocked;
    assign in_stall = blocked;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next = blocked || accept;

    always_comb
    begin
        running_crc_next = running_crc_reg;
        if (advance)
        begin
            running_crc_next = s1_last_reg ? CRC_INIT : crc_upd;
        end
    end

    assign res.valid = advance && s1_last_reg;
    assign res.crc   = crc_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            running_crc_reg <= CRC_INIT;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            running_crc_reg <= running_crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

endmodule

// ----- sv/icv_result_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_result_stage
// Judges the section status and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module icv_result_stage
    import icv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  crc_res_t    res,
    output logic        res_full,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  section_status,
    output logic [31:0] computed_crc
);

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg;
    logic [31:0] crc_reg;
    status_t     status_calc;
    logic        uid_known;

    assign uid_known = (cfg.header_uid == cfg.part_identifier) ||
                       (cfg.header_uid == cfg.stack_identifier);

    always_comb
    begin
        priority if (cfg.backup_mode && (cfg.header_rom_version == ALL16 ||
                                         cfg.header_version == ALL16))
            status_calc = ST_ERASED;
        else if (!uid_known)
            status_calc = ST_UNKNOWN;
        else if (cfg.header_length == ALL16)
            status_calc = ST_ABNORMAL;
        else if (res.crc == cfg.expected_crc)
            status_calc = ST_NORMAL;
        else
            status_calc = ST_ABNORMAL;
    end

    assign res_full       = out_valid_reg && out_stall;
    assign out_valid_next = res.valid || res_full;

    assign out_valid      = out_valid_reg;
    assign section_status = status_reg;
    assign computed_crc   = crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= status_calc;
            crc_reg    <= res.crc;
        end
    end

endmodule

// ----- sv/image_crc32_verifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_crc32_verifier
// Streams image bytes through a reflected CRC-32 and judges the section.
// ----------------------------------------------------------------------------
// Usage:
//   Software loads the header fields over the APB port while the block is
//   idle. Image bytes arrive on the input channel (in_valid/in_stall), one
//   byte per cycle, with last_byte marking the end of the body. Only the
//   last byte produces a word on the output channel (out_valid/out_stall):
//   section_status and the un-inverted CRC over the body.
//   Throughput is one byte per cycle while in_stall is low; the byte-wide
//   CRC update sits between the input and result registers; a last byte
//   goes from the input register to the result register, raising out_valid.
//   While the receiver stalls, the result word holds in its register and
//   non-last bytes keep flowing; a further last byte stalls the input until
//   the result is taken.
//   Reset clears the configuration registers to zero, empties both stages
//   and sets the running CRC to all ones; it returns to all ones after
//   every last byte.
// ----------------------------------------------------------------------------
module image_crc32_verifier
    import icv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        section_status,
    output logic [31:0]       computed_crc
);

    cfg_t     cfg;
    crc_res_t res;
    logic     res_full;

    icv_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    icv_crc_stage u_crc_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res_full  (res_full),
        .res       (res)
    );

    icv_result_stage u_result_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .res            (res),
        .res_full       (res_full),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .section_status (section_status),
        .computed_crc   (computed_crc)
    );

`ifndef NO_ASSERTIONS
    // running CRC restarts after every finished image
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> (u_crc_stage.running_crc_reg == CRC_INIT))
        else $error("running CRC not restored after last byte");

    // a new result is only produced into a free or draining result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(out_valid && out_stall))
        else $error("result word overwritten while held");

    // input stalls only because a last byte waits on a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // a normal status always carries the expected CRC
    a_normal_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && section_status == ST_NORMAL) |->
            (computed_crc == cfg.expected_crc))
        else $error("normal status with mismatching CRC");
`endif

endmodule
